### src/fic_pkg.sv
// Package for the FIFO-replacement identifier cache: types, constants, cell control.
`timescale 1ns / 1ps
`default_nettype none
package fic_pkg;

	localparam int ID_W        = 32;
	localparam int CAP_W       = 6;
	localparam int OCC_W       = 6;
	localparam int DEPTH_DEF   = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CAP_RESET   = 32;

	// command kinds
	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_DUMP   = 1'b1;

	// register indexes
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] item_id;
	} cmd_t;

	typedef struct packed {
		logic             hit;
		logic             evicted_valid;
		logic [ID_W-1:0]  evicted_id;
		logic [OCC_W-1:0] occupancy;
		logic             entry_valid;
		logic [ID_W-1:0]  entry_id;
		logic             last;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_SHIFT  = 2'd1,
		OP_ROTATE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     vld_d;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

endpackage
`default_nettype wire

### src/fic_cell.sv
// One entry cell: holds an identifier and its valid bit, compares against the key.
`timescale 1ns / 1ps
`default_nettype none
module fic_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fic_pkg::cell_ctl_t      ctl,
	input  wire logic [fic_pkg::ID_W-1:0] lo_id,
	input  wire logic [fic_pkg::ID_W-1:0] hi_id,
	input  wire logic [fic_pkg::ID_W-1:0] key,
	output logic      [fic_pkg::ID_W-1:0] id,
	output logic                         match
);

	logic [fic_pkg::ID_W-1:0] id_q;
	logic                     vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.op == fic_pkg::OP_SHIFT) begin
			vld_q <= ctl.vld_d;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			fic_pkg::OP_SHIFT:  id_q <= lo_id;
			fic_pkg::OP_ROTATE: id_q <= hi_id;
			default:            id_q <= id_q;
		endcase
	end

	assign id    = id_q;
	assign match = vld_q && (id_q == key);

endmodule
`default_nettype wire

### src/fifo_recent_id_cache.sv
// Top level of the FIFO-replacement identifier cache: cell chain, control, APB register.
// Access: accepted when start & !busy, result on rsp_valid the next cycle; one per idle cycle.
// Dump: busy while the dump state emits the held entries (never when empty: its one beat
//   follows next cycle like an access); beats come one per cycle, the first registered from
//   the dump state entered on accept; the chain rotates one cell per cycle and is restored.
// Results cannot be stalled by the receiver; each beat is shown for exactly one cycle.
// Reset (arst_n low, asynchronous): cache empty, capacity = 32, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module fifo_recent_id_cache #(
	parameter int DEPTH = fic_pkg::DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// command side
	input  wire logic           start,
	input  wire fic_pkg::cmd_t  cmd,
	output logic                busy,
	// result side
	output logic                rsp_valid,
	output fic_pkg::rsp_t       rsp,
	// APB config
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [2:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic      [31:0]    prdata,
	output logic                pready
);

	localparam int CW = $clog2(DEPTH + 1);          // held count width
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// ---------------------------------------------------------------
	// Config register
	// ---------------------------------------------------------------
	logic [fic_pkg::CAP_W-1:0] capacity_q;
	logic                      reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == fic_pkg::REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= fic_pkg::CAP_W'(fic_pkg::CAP_RESET);
		end else if (psel && penable && pwrite && reg_sel) begin
			capacity_q <= pwdata[fic_pkg::CAP_W-1:0];
		end
	end

	assign prdata = reg_sel ? 32'(capacity_q) : 32'd0;

	// ---------------------------------------------------------------
	// Cell chain: cell 0 holds the newest entry, cell count-1 the oldest.
	// Insert shifts toward higher index; dump rotates the occupied cells
	// toward cell 0, with cell 0 wrapping to cell count-1.
	// ---------------------------------------------------------------
	logic [fic_pkg::ID_W-1:0] cell_id    [DEPTH];
	logic [DEPTH-1:0]         cell_match;
	fic_pkg::cell_ctl_t       cell_ctl   [DEPTH];

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_d;
	logic [CW-1:0]  k_q;
	fic_pkg::state_t state_q;

	logic accept;
	logic is_access;
	logic hit;
	logic full;
	logic insert;
	logic [7:0] cap_eff;
	logic [IW-1:0] oldest_idx;
	logic dump_step;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [fic_pkg::ID_W-1:0] lo_src;
			logic [fic_pkg::ID_W-1:0] hi_src;

			if (g == 0) begin : g_first
				assign lo_src = cmd.item_id;
			end else begin : g_mid
				assign lo_src = cell_id[g-1];
			end

			if (g == DEPTH - 1) begin : g_end
				assign hi_src = cell_id[0];
			end else begin : g_inner
				assign hi_src = (CW'(g) == count_q - 1'b1) ? cell_id[0] : cell_id[g+1];
			end

			fic_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (cell_ctl[g]),
				.lo_id (lo_src),
				.hi_id (hi_src),
				.key   (cmd.item_id),
				.id    (cell_id[g]),
				.match (cell_match[g])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// Access decode
	// ---------------------------------------------------------------
	assign busy      = (state_q == fic_pkg::ST_DUMP);
	assign accept    = start && !busy;
	assign is_access = (cmd.kind == fic_pkg::KIND_ACCESS);
	assign hit       = |cell_match;

	// capacity 0 acts as 1, above DEPTH saturates
	always_comb begin
		cap_eff = 8'(capacity_q);
		if (cap_eff == 8'd0) begin
			cap_eff = 8'd1;
		end
		if (cap_eff > 8'(DEPTH)) begin
			cap_eff = 8'(DEPTH);
		end
	end

	assign full       = (8'(count_q) >= cap_eff);
	assign insert     = accept && is_access && !hit;
	assign oldest_idx = IW'(count_q - 1'b1);
	assign dump_step  = (state_q == fic_pkg::ST_DUMP);

	// eviction keeps the count; a plain insert grows it
	assign count_d = (insert && !full) ? count_q + 1'b1 : count_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].op    = fic_pkg::OP_HOLD;
			cell_ctl[i].vld_d = (CW'(i) < count_d);
			if (insert) begin
				cell_ctl[i].op = fic_pkg::OP_SHIFT;
			end else if (dump_step && (CW'(i) < count_q)) begin
				cell_ctl[i].op = fic_pkg::OP_ROTATE;
			end
		end
	end

	// ---------------------------------------------------------------
	// Control: count, dump sequencer
	// ---------------------------------------------------------------
	logic [7:0] n_emit;     // beats a dump emits
	logic       dump_last;
	logic       dump_emit;

	assign n_emit    = (8'(count_q) > 8'(fic_pkg::MAX_RESULTS)) ?
	                   8'(fic_pkg::MAX_RESULTS) : 8'(count_q);
	assign dump_emit = (8'(k_q) < n_emit);
	assign dump_last = (8'(k_q) == n_emit - 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fic_pkg::ST_IDLE;
			count_q <= '0;
			k_q     <= '0;
		end else begin
			count_q <= count_d;
			case (state_q)
				fic_pkg::ST_IDLE: begin
					if (accept && !is_access && (count_q != '0)) begin
						state_q <= fic_pkg::ST_DUMP;
						k_q     <= '0;
					end
				end
				fic_pkg::ST_DUMP: begin
					k_q <= k_q + 1'b1;
					if (k_q == count_q - 1'b1) begin
						state_q <= fic_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fic_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	fic_pkg::rsp_t rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else begin
			rsp_valid <= (accept && (is_access || count_q == '0)) ||
			             (dump_step && dump_emit);
		end
	end

	always_comb begin
		rsp_d = '0;
		if (dump_step) begin
			rsp_d.occupancy   = fic_pkg::OCC_W'(count_q);
			rsp_d.entry_valid = 1'b1;
			rsp_d.entry_id    = cell_id[0];
			rsp_d.last        = dump_last;
		end else if (accept && is_access) begin
			rsp_d.hit           = hit;
			rsp_d.evicted_valid = insert && full;
			rsp_d.evicted_id    = (insert && full) ? cell_id[oldest_idx] : '0;
			rsp_d.occupancy     = fic_pkg::OCC_W'(count_d);
			rsp_d.last          = 1'b1;
		end else begin
			// empty dump: all zero, marked last
			rsp_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rsp <= rsp_d;
	end

endmodule
`default_nettype wire
